// File: hw/rtl/fcfc_pkg.sv
package fcfc_pkg;

  // Verdict codes
  localparam logic [1:0] VERDICT_EXCLUDED  = 2'd0;
  localparam logic [1:0] VERDICT_DETECTED  = 2'd1;
  localparam logic [1:0] VERDICT_UNDECIDED = 2'd2;
  localparam logic [1:0] VERDICT_SKIPPED   = 2'd3;

  // Bits of the seen-codes mask
  localparam logic [4:0] MASK_USER  = 5'b00001;
  localparam logic [4:0] MASK_FEAT  = 5'b00010;
  localparam logic [4:0] MASK_220   = 5'b00100;
  localparam logic [4:0] MASK_331   = 5'b01000;
  localparam logic [4:0] MASK_211   = 5'b10000;
  localparam logic [4:0] MASK_CMDS  = 5'b00011;
  localparam logic [4:0] MASK_CODES = 5'b11100;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_CONTROL_PORT        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NO_CODE_LIMIT       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WAIT_OTHER          = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WAIT_OTHER_GREETING = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_WAIT_PORT           = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_WAIT_PORT_GREETING  = 3'd5;

  // Register reset values
  localparam logic [15:0] RST_CONTROL_PORT        = 16'd21;
  localparam logic [15:0] RST_NO_CODE_LIMIT       = 16'd3;
  localparam logic [15:0] RST_WAIT_OTHER          = 16'd10;
  localparam logic [15:0] RST_WAIT_OTHER_GREETING = 16'd20;
  localparam logic [15:0] RST_WAIT_PORT           = 16'd20;
  localparam logic [15:0] RST_WAIT_PORT_GREETING  = 16'd40;

  // Token patterns (first payload bytes)
  localparam logic [39:0] TOK_USER_UC = 40'h5553455220; // "USER "
  localparam logic [39:0] TOK_USER_LC = 40'h7573657220; // "user "
  localparam logic [31:0] TOK_FEAT_UC = 32'h46454154;   // "FEAT"
  localparam logic [31:0] TOK_FEAT_LC = 32'h66656174;   // "feat"
  localparam logic [23:0] TOK_220     = 24'h323230;     // "220"
  localparam logic [23:0] TOK_331     = 24'h333331;     // "331"
  localparam logic [23:0] TOK_211     = 24'h323131;     // "211"
  localparam logic [7:0]  CHR_SPACE   = 8'h20;
  localparam logic [7:0]  CHR_DASH    = 8'h2d;

  typedef struct packed {
    logic [39:0] payload_head;
    logic [15:0] payload_length;
    logic        pkt_dir;
    logic        setup_direction;
    logic        syn_seen;
    logic [15:0] packet_index;
    logic [15:0] source_port;
    logic [15:0] dest_port;
  } fcfc_in_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic [4:0] codes_seen;
    logic       client_side;
  } fcfc_out_t;

endpackage

// File: hw/rtl/ftp_control_flow_classifier.sv
// FTP control-flow classifier.
// One request on the input channel (in_valid/in_ready/in_data) carries the
// summary of one packet of a single TCP flow: first five payload bytes,
// length, direction, SYN fact, packet index and ports. For every request the
// block returns exactly one result on the output channel (out_valid/
// out_ready/out_data): verdict, the mask of FTP codes seen, and the client
// direction. Registers are written through the cfg channel (cfg_valid/
// cfg_ready/cfg_index/cfg_data), always ready. The user must write them only
// while the block is idle; the block does not enforce it. Throughput: one
// request per cycle while the receiver takes results; all classification is a
// handful of byte compares and 16-bit limit compares between the input
// handshake and the result register; the flow state updates in the same edge.
// When the receiver stalls, the result register holds and in_ready drops, so
// at most one result waits; in_ready returns as soon as it is taken.
// Reset (rst, synchronous) loads register defaults (port 21, limits 3, 10,
// 20, 20, 40), clears the flow state to client 0, empty mask, undecided,
// and empties the result register. A request with packet index 1 restarts
// the flow state on its own.
module ftp_control_flow_classifier
  import fcfc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  fcfc_in_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output fcfc_out_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_data
);

  // Configuration registers
  logic [15:0] control_port;
  logic [15:0] no_code_limit;
  logic [15:0] wait_other;
  logic [15:0] wait_other_greeting;
  logic [15:0] wait_port;
  logic [15:0] wait_port_greeting;

  // Flow state
  logic       client_dir;
  logic [4:0] seen_mask;
  logic [1:0] outcome;
  logic       client_dir_next;
  logic [4:0] seen_mask_next;
  logic [1:0] outcome_next;
  logic [1:0] verdict_next;

  logic       in_fire;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_print(input logic [7:0] c);
    return c >= CHR_SPACE && c <= 8'h7f;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      control_port        <= RST_CONTROL_PORT;
      no_code_limit       <= RST_NO_CODE_LIMIT;
      wait_other          <= RST_WAIT_OTHER;
      wait_other_greeting <= RST_WAIT_OTHER_GREETING;
      wait_port           <= RST_WAIT_PORT;
      wait_port_greeting  <= RST_WAIT_PORT_GREETING;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CONTROL_PORT:        control_port        <= cfg_data;
        REG_NO_CODE_LIMIT:       no_code_limit       <= cfg_data;
        REG_WAIT_OTHER:          wait_other          <= cfg_data;
        REG_WAIT_OTHER_GREETING: wait_other_greeting <= cfg_data;
        REG_WAIT_PORT:           wait_port           <= cfg_data;
        REG_WAIT_PORT_GREETING:  wait_port_greeting  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classification of the request at the input
  logic [7:0]  b [5];
  logic [15:0] len;
  logic [15:0] idx;
  logic        pdir;
  logic        sdir;
  logic        first;
  logic        base_dir;
  logic [4:0]  base_mask;
  logic [1:0]  base_outcome;
  logic        cdir;
  logic [4:0]  cur;
  logic        shape_fail;
  logic        cmd_shape;
  logic        reply_shape;
  logic        cont_shape;
  logic        on_port;
  logic [15:0] wait_limit;
  logic [4:0]  new_mask;
  logic [1:0]  classified;

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      b[i] = in_data.payload_head[39 - 8*i -: 8];
    end
    len   = in_data.payload_length;
    idx   = in_data.packet_index;
    pdir  = in_data.pkt_dir;
    sdir  = in_data.setup_direction;
    first = (idx == 16'd1);

    // Packet index 1 restarts the flow before anything else
    base_dir     = first ? 1'b0 : client_dir;
    base_mask    = first ? 5'd0 : seen_mask;
    base_outcome = first ? VERDICT_UNDECIDED : outcome;

    // Fix the client side on the first packet
    if (!first) begin
      cdir = client_dir;
    end else if (in_data.syn_seen) begin
      cdir = sdir;
    end else if (is_digit(b[0])) begin
      cdir = !pdir;
    end else begin
      cdir = pdir;
    end

    cmd_shape = (len >= 16'd3) && is_alpha(b[0]) && is_alpha(b[1]) && is_alpha(b[2]);
    if (len > 16'd3) begin
      if (!is_alpha(b[3]) && b[3] != CHR_SPACE) begin
        cmd_shape = 1'b0;
      end
      if (len > 16'd4 && b[3] != CHR_SPACE && b[4] != CHR_SPACE) begin
        cmd_shape = 1'b0;
      end
    end
    reply_shape = (len >= 16'd5) && (b[3] == CHR_SPACE || b[3] == CHR_DASH) &&
                  is_digit(b[0]) && is_digit(b[1]) && is_digit(b[2]);
    cont_shape  = (len >= 16'd5) && is_print(b[0]) && is_print(b[1]) &&
                  is_print(b[2]) && is_print(b[3]) && is_print(b[4]);

    cur        = 5'd0;
    shape_fail = 1'b0;
    if (pdir == cdir) begin
      // Client side: commands
      if (len > 16'd5 && (in_data.payload_head == TOK_USER_UC ||
                          in_data.payload_head == TOK_USER_LC)) begin
        cur = MASK_USER;
      end else if (len >= 16'd4 && ({b[0], b[1], b[2], b[3]} == TOK_FEAT_UC ||
                                    {b[0], b[1], b[2], b[3]} == TOK_FEAT_LC)) begin
        cur = MASK_FEAT;
      end else if (!cmd_shape) begin
        shape_fail = 1'b1;
      end
    end else begin
      // Server side: replies
      if (len > 16'd4 && {b[0], b[1], b[2]} == TOK_220 &&
          (b[3] == CHR_SPACE || b[3] == CHR_DASH)) begin
        cur = MASK_220;
      end else if (len > 16'd4 && {b[0], b[1], b[2]} == TOK_331 &&
                   (b[3] == CHR_SPACE || b[3] == CHR_DASH)) begin
        cur = MASK_331;
      end else if (len > 16'd4 && {b[0], b[1], b[2]} == TOK_211 &&
                   (b[3] == CHR_SPACE || b[3] == CHR_DASH)) begin
        cur = MASK_211;
      end else if (!reply_shape) begin
        if ((base_mask & MASK_CODES) == 5'd0 || !cont_shape) begin
          shape_fail = 1'b1;
        end
      end
    end
    new_mask = base_mask | cur;

    on_port = (pdir == sdir) ? (in_data.dest_port == control_port)
                             : (in_data.source_port == control_port);
    if (on_port) begin
      wait_limit = (cur == MASK_220) ? wait_port_greeting : wait_port;
    end else begin
      wait_limit = (cur == MASK_220) ? wait_other_greeting : wait_other;
    end

    if (shape_fail) begin
      classified = VERDICT_EXCLUDED;
    end else if ((new_mask & MASK_CMDS) != 5'd0 && (new_mask & MASK_CODES) != 5'd0) begin
      classified = VERDICT_DETECTED;
    end else if (new_mask == 5'd0 && idx > no_code_limit) begin
      classified = VERDICT_EXCLUDED;
    end else if (idx > wait_limit) begin
      classified = VERDICT_EXCLUDED;
    end else begin
      classified = VERDICT_UNDECIDED;
    end

    // Latched verdicts hold; empty payloads are skipped, touching state only by the index-1 restart
    client_dir_next = base_dir;
    seen_mask_next  = base_mask;
    outcome_next    = base_outcome;
    if (base_outcome == VERDICT_EXCLUDED || base_outcome == VERDICT_DETECTED) begin
      verdict_next = base_outcome;
    end else if (len == 16'd0) begin
      verdict_next = VERDICT_SKIPPED;
    end else begin
      verdict_next    = classified;
      client_dir_next = cdir;
      seen_mask_next  = shape_fail ? base_mask : new_mask;
      outcome_next    = classified;
    end
  end

  // Flow state advances on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      client_dir <= 1'b0;
      seen_mask  <= 5'd0;
      outcome    <= VERDICT_UNDECIDED;
    end else if (in_fire) begin
      client_dir <= client_dir_next;
      seen_mask  <= seen_mask_next;
      outcome    <= outcome_next;
    end
  end

  // Result register: load on accept, hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data.verdict     <= verdict_next;
      out_data.codes_seen  <= seen_mask_next;
      out_data.client_side <= client_dir_next;
    end
  end

endmodule
